### rtl/core/pst_pkg.sv
// Package for the pan-tilt scan sequencer: command and register codes,
// result and bundle types, Q4.12 thresholds and 12-bit signed speeds.
// No dependencies.
package pst_pkg;

  // Command codes of an input request
  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_SAMPLE = 2'd1,
    CMD_START  = 2'd2
  } cmd_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_SCAN_END   = 2'd0,
    REG_SCAN_START = 2'd1,
    REG_SCAN_SPEED = 2'd2,
    REG_RECOVERY   = 2'd3
  } reg_e;

  // Result kinds and joints
  localparam logic KIND_VEL    = 1'b0;
  localparam logic KIND_DONE   = 1'b1;
  localparam logic JOINT_PAN   = 1'b0;
  localparam logic JOINT_TILT  = 1'b1;

  localparam int unsigned ANGLE_W = 16;
  localparam int unsigned VEL_W   = 12;
  localparam int unsigned MAX_RES = 4;
  localparam int unsigned CNT_W   = $clog2(MAX_RES + 1);
  localparam int unsigned IDX_W   = $clog2(MAX_RES);
  localparam int unsigned QDEPTH  = 2;
  localparam int unsigned QPTR_W  = $clog2(QDEPTH);
  localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

  // Q4.12 angle constants and 12-bit signed speeds
  localparam logic signed [ANGLE_W-1:0] BAND_HI      = -16'sd12861;
  localparam logic signed [ANGLE_W-1:0] BAND_LO      = -16'sd12902;
  localparam logic signed [ANGLE_W:0]   JUMP_LIMIT   = 17'sd1229;
  localparam logic signed [ANGLE_W-1:0] CENTRE_WIN   = 16'sd410;
  localparam logic signed [ANGLE_W-1:0] TILT_NEAR    = 16'sd1229;
  localparam logic signed [ANGLE_W-1:0] SETTLE_WIN   = 16'sd41;
  localparam logic signed [ANGLE_W-1:0] SLOW_ZONE    = -16'sd715;
  localparam logic signed [VEL_W-1:0]   VEL_FAST     = 12'sd410;
  localparam logic signed [VEL_W-1:0]   VEL_SLOW     = 12'sd123;
  localparam logic signed [VEL_W-1:0]   VEL_ZERO     = 12'sd0;

  // Register reset values
  localparam logic signed [ANGLE_W-1:0] RST_SCAN_END   = -16'sd12861;
  localparam logic signed [ANGLE_W-1:0] RST_SCAN_START = 16'sd0;
  localparam logic signed [VEL_W-1:0]   RST_SCAN_SPEED = -12'sd102;
  localparam logic signed [VEL_W-1:0]   RST_RECOVERY   = 12'sd1229;

  typedef struct packed {
    logic                    kind;
    logic                    joint;
    logic signed [VEL_W-1:0] velocity;
  } result_t;

  // All results caused by one request
  typedef struct packed {
    logic [CNT_W-1:0]          count;
    result_t [MAX_RES-1:0]     res;
  } bundle_t;

endpackage

### rtl/core/pst_front.sv
// Front end: accepts requests and configuration writes, runs the glitch
// filter and the sequencing flags, and builds one result bundle per request.
// Depends on pst_pkg.
module pst_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [1:0]             command_i,
  input  logic signed [15:0]     pan_position_i,
  input  logic signed [15:0]     tilt_position_i,
  input  logic                   start_flag_i,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [1:0]             cfg_index_i,
  input  logic [15:0]            cfg_data_i,
  input  logic                   q_full_i,
  output logic                   push_o,
  output pst_pkg::bundle_t       bundle_o
);

  logic signed [pst_pkg::ANGLE_W-1:0] scan_end_q, scan_start_q;
  logic signed [pst_pkg::VEL_W-1:0]   scan_speed_q, recovery_q;

  logic signed [pst_pkg::ANGLE_W-1:0] pan_angle_q, pan_angle_d;
  logic signed [pst_pkg::ANGLE_W-1:0] held_pan_q, held_pan_d;
  logic held_valid_q, held_valid_d;
  logic scanning_q, scanning_d;
  logic recovering_q, recovering_d;
  logic init_q, init_d;
  logic cpan_q, cpan_d;
  logic ctilt_q, ctilt_d;

  logic accept;
  pst_pkg::result_t [pst_pkg::MAX_RES-1:0] cand;
  logic [pst_pkg::MAX_RES-1:0]             cand_en;
  pst_pkg::bundle_t                        bundle;

  logic signed [pst_pkg::ANGLE_W-1:0] held_eff, pan_f;
  logic signed [pst_pkg::ANGLE_W:0]   diff;
  logic glitch;

  assign in_ready_o  = !q_full_i;
  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i && in_ready_o;

  // Glitch filter: hold last pan on a big jump inside the wrap band
  always_comb begin
    held_eff = held_valid_q ? held_pan_q : pan_position_i;
    diff     = {held_eff[15], held_eff} - {pan_position_i[15], pan_position_i};
    glitch   = (diff > pst_pkg::JUMP_LIMIT || diff < -pst_pkg::JUMP_LIMIT)
               && pan_position_i < pst_pkg::BAND_HI
               && pan_position_i > pst_pkg::BAND_LO;
    pan_f    = glitch ? held_eff : pan_position_i;
  end

  always_comb begin
    pan_angle_d  = pan_angle_q;
    held_pan_d   = held_pan_q;
    held_valid_d = held_valid_q;
    scanning_d   = scanning_q;
    recovering_d = recovering_q;
    init_d       = init_q;
    cpan_d       = cpan_q;
    ctilt_d      = ctilt_q;
    cand         = '0;
    cand_en      = '0;
    case (pst_pkg::cmd_e'(command_i))
      pst_pkg::CMD_TICK: begin
        cand[1].kind     = pst_pkg::KIND_VEL;
        cand[1].joint    = pst_pkg::JOINT_PAN;
        cand[1].velocity = pst_pkg::VEL_ZERO;
        cand_en[1]       = 1'b1;
        if (scanning_q) begin
          cand[1].velocity = scan_speed_q;
          if (pan_angle_q < scan_end_q) begin
            scanning_d     = 1'b0;
            recovering_d   = 1'b1;
            cand[0].kind   = pst_pkg::KIND_DONE;
            cand_en[0]     = 1'b1;
          end
        end
        if (recovering_d) begin
          cand[1].velocity = recovery_q;
          if (pan_angle_q > pst_pkg::SLOW_ZONE) begin
            cand[1].velocity = pst_pkg::VEL_FAST;
          end
          if (pan_angle_q > scan_start_q) begin
            cand[1].velocity = pst_pkg::VEL_ZERO;
            recovering_d     = 1'b0;
          end
        end
      end
      pst_pkg::CMD_SAMPLE: begin
        held_valid_d = 1'b1;
        held_pan_d   = pan_f;
        pan_angle_d  = pan_f;
        if (init_q) begin
          cand[0].kind     = pst_pkg::KIND_VEL;
          cand[0].joint    = pst_pkg::JOINT_PAN;
          cand[0].velocity = (pan_f < 0) ? pst_pkg::VEL_FAST : -pst_pkg::VEL_FAST;
          cand_en[0]       = cpan_q;
          if (pan_f > -pst_pkg::CENTRE_WIN && pan_f < pst_pkg::CENTRE_WIN) begin
            cpan_d  = 1'b0;
            ctilt_d = 1'b1;
          end
          cand[1].kind  = pst_pkg::KIND_VEL;
          cand[1].joint = pst_pkg::JOINT_TILT;
          if (tilt_position_i < 0) begin
            cand[1].velocity = (tilt_position_i > -pst_pkg::TILT_NEAR) ?
                               pst_pkg::VEL_SLOW : pst_pkg::VEL_FAST;
          end else begin
            cand[1].velocity = (tilt_position_i < pst_pkg::TILT_NEAR) ?
                               -pst_pkg::VEL_SLOW : -pst_pkg::VEL_FAST;
          end
          cand_en[1] = ctilt_d;
          // tilt settled: notice, then tilt stop
          if (tilt_position_i > -pst_pkg::SETTLE_WIN &&
              tilt_position_i < pst_pkg::SETTLE_WIN) begin
            cpan_d           = 1'b0;
            ctilt_d          = 1'b0;
            init_d           = 1'b0;
            cand[2].kind     = pst_pkg::KIND_DONE;
            cand_en[2]       = 1'b1;
            cand[3].kind     = pst_pkg::KIND_VEL;
            cand[3].joint    = pst_pkg::JOINT_TILT;
            cand[3].velocity = pst_pkg::VEL_ZERO;
            cand_en[3]       = 1'b1;
          end
        end
      end
      pst_pkg::CMD_START: begin
        scanning_d = start_flag_i;
      end
      default: begin
      end
    endcase
  end

  // Pack enabled candidates in order
  always_comb begin
    bundle = '0;
    for (int i = 0; i < pst_pkg::MAX_RES; i++) begin
      if (cand_en[i]) begin
        bundle.res[bundle.count[pst_pkg::IDX_W-1:0]] = cand[i];
        bundle.count = bundle.count + 1'b1;
      end
    end
  end

  assign bundle_o = bundle;
  assign push_o   = accept && (bundle.count != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_end_q   <= pst_pkg::RST_SCAN_END;
      scan_start_q <= pst_pkg::RST_SCAN_START;
      scan_speed_q <= pst_pkg::RST_SCAN_SPEED;
      recovery_q   <= pst_pkg::RST_RECOVERY;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (pst_pkg::reg_e'(cfg_index_i))
        pst_pkg::REG_SCAN_END:   scan_end_q   <= cfg_data_i;
        pst_pkg::REG_SCAN_START: scan_start_q <= cfg_data_i;
        pst_pkg::REG_SCAN_SPEED: scan_speed_q <= cfg_data_i[pst_pkg::VEL_W-1:0];
        pst_pkg::REG_RECOVERY:   recovery_q   <= cfg_data_i[pst_pkg::VEL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pan_angle_q  <= '0;
      held_pan_q   <= '0;
      held_valid_q <= 1'b0;
      scanning_q   <= 1'b0;
      recovering_q <= 1'b0;
      init_q       <= 1'b1;
      cpan_q       <= 1'b1;
      ctilt_q      <= 1'b0;
    end else if (accept) begin
      pan_angle_q  <= pan_angle_d;
      held_pan_q   <= held_pan_d;
      held_valid_q <= held_valid_d;
      scanning_q   <= scanning_d;
      recovering_q <= recovering_d;
      init_q       <= init_d;
      cpan_q       <= cpan_d;
      ctilt_q      <= ctilt_d;
    end
  end

endmodule

### rtl/core/pst_queue.sv
// Short bundle queue between front and back end.
// Depends on pst_pkg.
module pst_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  pst_pkg::bundle_t bundle_i,
  input  logic             pop_i,
  output logic             full_o,
  output logic             valid_o,
  output pst_pkg::bundle_t head_o
);

  pst_pkg::bundle_t                 mem_q [pst_pkg::QDEPTH];
  logic [pst_pkg::QPTR_W-1:0]       wr_q, wr_d, rd_q, rd_d;
  logic [pst_pkg::QCNT_W-1:0]       cnt_q, cnt_d;

  assign full_o  = (cnt_q == pst_pkg::QCNT_W'(pst_pkg::QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? wr_q + 1'b1 : wr_q;
    rd_d  = pop_i  ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q;
    if (push_i && !pop_i) cnt_d = cnt_q + 1'b1;
    if (pop_i && !push_i) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= bundle_i;
    end
  end

endmodule

### rtl/core/pst_back.sv
// Back end: steps through the head bundle, one result a cycle unless output stalls.
// Depends on pst_pkg.
module pst_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    head_valid_i,
  input  pst_pkg::bundle_t        head_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic                    kind_o,
  output logic                    joint_o,
  output logic signed [11:0]      velocity_o,
  output logic                    last_o
);

  logic [pst_pkg::IDX_W-1:0] idx_q, idx_d;
  logic fire;
  pst_pkg::result_t cur;

  assign cur         = head_i.res[idx_q];
  assign out_valid_o = head_valid_i;
  assign kind_o      = cur.kind;
  assign joint_o     = cur.joint;
  assign velocity_o  = cur.velocity;
  assign last_o      = ({1'b0, idx_q} == head_i.count - 1'b1);
  assign fire        = out_valid_o && out_ready_i;
  assign pop_o       = fire && last_o;

  always_comb begin
    idx_d = idx_q;
    if (fire) idx_d = last_o ? '0 : idx_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

endmodule

### rtl/core/pan_tilt_scan_sequencer.sv
// Top level of the pan-tilt scan sequencer: front end, bundle queue, back end.
// Depends on pst_pkg, pst_front, pst_queue, pst_back.
//
// Channel  Direction  Handshake               Payload
// in       input      in_valid_i/in_ready_o   command, pan/tilt position, start flag
// out      output     out_valid_o/out_ready_i kind, joint, velocity, last
// cfg      input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// A request is accepted whenever the two-entry bundle queue has room; its
// state update is registered when it is accepted.
// Results leave one per cycle while out_ready_i is high; a queued request
// carries 1 to 4 results, presented in order before its bundle is popped.
// Reset is asynchronous, active low; registers return to their defaults and
// no clearing pass is needed. cfg_ready_o is always high.
// A stalled output holds the head bundle; the front keeps accepting until the
// queue is full.
module pan_tilt_scan_sequencer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         command_i,
  input  logic signed [15:0] pan_position_i,
  input  logic signed [15:0] tilt_position_i,
  input  logic               start_flag_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               kind_o,
  output logic               joint_o,
  output logic signed [11:0] velocity_o,
  output logic               last_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i
);

  logic             push, pop, q_full, head_valid;
  pst_pkg::bundle_t bundle, head;

  // Front: classifies the request and updates sequencing state
  pst_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .command_i       (command_i),
    .pan_position_i  (pan_position_i),
    .tilt_position_i (tilt_position_i),
    .start_flag_i    (start_flag_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .q_full_i        (q_full),
    .push_o          (push),
    .bundle_o        (bundle)
  );

  // Only requests that cause results are queued
  pst_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .bundle_i (bundle),
    .pop_i    (pop),
    .full_o   (q_full),
    .valid_o  (head_valid),
    .head_o   (head)
  );

  // Back: serialises the head bundle onto the output channel
  pst_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .kind_o       (kind_o),
    .joint_o      (joint_o),
    .velocity_o   (velocity_o),
    .last_o       (last_o)
  );

endmodule

### rtl/core/pst_checker.sv
// Port-level checks for the pan-tilt scan sequencer, bound to the top level.
// Depends on pan_tilt_scan_sequencer ports only.
module pst_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic               kind_o,
  input logic               joint_o,
  input logic signed [11:0] velocity_o,
  input logic               last_o
);

  // Stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output dropped while stalled");

  // Stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      $stable(kind_o) && $stable(joint_o) && $stable(velocity_o) && $stable(last_o))
    else $error("output payload changed while stalled");

  // A finished notice carries no joint and no speed
  a_done_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o |-> !joint_o && velocity_o == 12'sd0)
    else $error("finished notice with payload");

  // A finished notice is always followed by a velocity in the same request
  a_done_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o |-> !last_o)
    else $error("finished notice closed a request");

endmodule

bind pan_tilt_scan_sequencer pst_checker u_pst_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .kind_o      (kind_o),
  .joint_o     (joint_o),
  .velocity_o  (velocity_o),
  .last_o      (last_o)
);
